FILE: rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types, constants and helpers for the vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int IDX_W         = 4;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  // quotient bits kept by the divider, one above the 32-bit result
  localparam int QB            = COORD_W + 1;
  localparam int MAC_LAT       = 2;
  localparam int DIV_LAT       = QB + 2;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SAT   = 2'd1,
    STAT_WZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } div_res_t;

  // row r, column c, both from 0; even columns sit in the high half
  function automatic logic signed [COORD_W-1:0] mat_entry(mat_t m, int r, int c);
    logic [REG_W-1:0] rv;
    rv = m[(r << 1) | (c >> 1)];
    return (c % 2 == 1) ? $signed(rv[COORD_W-1:0]) : $signed(rv[REG_W-1:COORD_W]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vtpd_mac.sv
// ----------------------------------------------------------------------------
// vtpd_mac
// Two-stage matrix multiply: twelve products, then four column sums.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_mac import vtpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW        = 66 - FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire mat_t                      mat_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  input  wire logic signed [COORD_W-1:0] y_i,
  input  wire logic signed [COORD_W-1:0] z_i,
  output logic signed [SW-1:0]           col_o [4]
);

  logic signed [PROD_W-1:0]  prod_q [3][4];
  logic signed [COORD_W-1:0] off_q  [4];
  logic signed [SW-1:0]      col_q  [4];
  logic signed [COORD_W-1:0] pt     [3];

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[r][c] <= PROD_W'(pt[r]) * PROD_W'(mat_entry(mat_i, r, c));
        end
        off_q[c] <= mat_entry(mat_i, 3, c);
      end
    end
  end

  // arithmetic shift floors each product; the sum cannot leave 64 bits
  always_ff @(posedge clk_i) begin
    logic signed [PROD_W-1:0] acc;
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        acc = PROD_W'(off_q[c]) + (prod_q[0][c] >>> FRAC_BITS)
            + (prod_q[1][c] >>> FRAC_BITS) + (prod_q[2][c] >>> FRAC_BITS);
        col_q[c] <= acc[SW-1:0];
      end
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: rtl/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div import vtpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW        = 66 - FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic signed [SW-1:0] num_i,
  input  wire logic signed [SW-1:0] w_i,
  output div_res_t               res_o
);

  localparam int RW = SW + QB + 1;

  logic [RW-1:0] rem_q [QB+1];
  logic [SW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  div_ctl_t      ctl_q [QB+1];
  div_res_t      res_q;

  logic [SW-1:0] n_mag, d_mag;
  logic [RW-1:0] n_ext;

  assign n_mag = num_i[SW-1] ? SW'(-num_i) : num_i;
  assign d_mag = w_i[SW-1]   ? SW'(-w_i)   : w_i;
  assign n_ext = RW'(n_mag) << FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]     <= n_ext;
      den_q[0]     <= d_mag;
      quo_q[0]     <= '0;
      ctl_q[0].neg <= num_i[SW-1] ^ w_i[SW-1];
      // quotient would not fit in QB bits
      ctl_q[0].ovf <= n_ext >= (RW'(d_mag) << QB);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den_q[k]) << SH;
    assign ge  = rem_q[k] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
        ctl_q[k+1] <= ctl_q[k];
      end
    end
  end

  logic [QB-1:0]      q;
  logic               sat;
  logic [COORD_W-1:0] val;

  assign q = quo_q[QB];

  always_comb begin
    if (ctl_q[QB].neg) begin
      sat = ctl_q[QB].ovf || (q > QB'(64'h8000_0000));
      val = sat ? 32'h8000_0000 : (~q[COORD_W-1:0] + 32'd1);
    end else begin
      sat = ctl_q[QB].ovf || q[QB-1] || q[COORD_W-1];
      val = sat ? 32'h7FFF_FFFF : q[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.val <= val;
      res_q.sat <= sat;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/vertex_transform_perspective_divide_core.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_core
// 4x4 homogeneous point transform with perspective divide, fixed point.
// ----------------------------------------------------------------------------
// Accepts one point per clock unless the sink stalls, and returns one
// projected point per point, in order. The products and then the column
// sums are registered, then a divider pipeline resolves one quotient bit
// per stage (33 stages) plus a setup and a saturation stage, then the
// output register. The whole pipeline advances whenever the output
// register is empty or being taken, so a stalled sink holds every stage.
// Matrix writes take effect on the next accepted point; write only when idle.
`default_nettype none

module vertex_transform_perspective_divide_core import vtpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [COORD_W-1:0] x_in_i,
  input  wire logic [COORD_W-1:0] y_in_i,
  input  wire logic [COORD_W-1:0] z_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [COORD_W-1:0]      x_out_o,
  output logic [COORD_W-1:0]      y_out_o,
  output logic [COORD_W-1:0]      z_out_o,
  output logic [1:0]              status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [IDX_W-1:0]   cfg_idx_i,
  input  wire logic [REG_W-1:0]   cfg_wdata_i
);

  localparam int SW   = 66 - FRAC_BITS;
  localparam int PIPE = MAC_LAT + DIV_LAT;
  localparam logic [REG_W-1:0] ONE = REG_W'(1) << FRAC_BITS;

  mat_t                mat_q;
  logic                en;
  logic [PIPE-1:0]     vld_q;
  logic [DIV_LAT-1:0]  wz_q;
  logic signed [SW-1:0] col [4];
  div_res_t            res [3];

  logic                out_valid_q;
  logic [COORD_W-1:0]  x_q, y_q, z_q;
  status_e             status_q, status_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= ONE << 32;
      mat_q[1] <= '0;
      mat_q[2] <= ONE;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= ONE << 32;
      mat_q[6] <= '0;
      mat_q[7] <= ONE;
    end else if (cfg_we_i && (cfg_idx_i < IDX_W'(NUM_REGS))) begin
      mat_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  vtpd_mac #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_mac (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (mat_q),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .z_i   (z_in_i),
    .col_o (col)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    vtpd_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (col[c]),
      .w_i   (col[3]),
      .res_o (res[c])
    );
  end

  // valid bits and the zero-w flag ride alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wz_q <= {wz_q[DIV_LAT-2:0], col[3] == '0};
    end
  end

  always_comb begin
    if (wz_q[DIV_LAT-1]) begin
      status_d = STAT_WZERO;
    end else if (res[0].sat || res[1].sat || res[2].sat) begin
      status_d = STAT_SAT;
    end else begin
      status_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[PIPE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q      <= wz_q[DIV_LAT-1] ? '0 : res[0].val;
      y_q      <= wz_q[DIV_LAT-1] ? '0 : res[1].val;
      z_q      <= wz_q[DIV_LAT-1] ? '0 : res[2].val;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_q;
  assign y_out_o     = y_q;
  assign z_out_o     = z_q;
  assign status_o    = status_q;

  a_wzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_WZERO) |->
      (x_out_o == '0) && (y_out_o == '0) && (z_out_o == '0))
    else $error("zero w beat carries nonzero coordinates");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK) || (status_o == STAT_SAT) ||
      (status_o == STAT_WZERO))
    else $error("undefined status code on output");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat lost at pipeline entry");

  a_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PIPE-1] && en |=> out_valid_o)
    else $error("beat lost between divider and output register");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex transform with perspective divide: a
// directed table then random points over several matrices, with random
// source bursts and sink stalls, each result checked against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import vtpd_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int LAT       = MAC_LAT + DIV_LAT + 1;
  localparam int MAX_CYC   = 400000;
  localparam int N_DIR     = 14;
  localparam int N_RAND    = 400;
  localparam logic [63:0] ONE = 64'd1 << FB;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    status_e     st;
  } proj_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        chk;
    proj_t       res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] x_in_i = '0, y_in_i = '0, z_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] x_out_o, y_out_o, z_out_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_wdata_i = '0;

  logic [63:0] matrix [NUM_REGS];
  proj_t expected_q [$];
  int n_mismatch = 0;
  int cycles = 0;
  bit sink_busy = 1'b0;

  vertex_transform_perspective_divide_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [63:0] entry_of(int r, int c);
    logic [63:0] rv;
    rv = matrix[r * 2 + c / 2];
    return (c % 2 == 1) ? 64'(signed'(rv[31:0])) : 64'(signed'(rv[63:32]));
  endfunction

  function automatic logic signed [127:0] column_sum(logic signed [63:0] p [3], int c);
    logic signed [127:0] acc;
    logic signed [127:0] prod;
    acc = 128'(entry_of(3, c));
    for (int r = 0; r < 3; r++) begin
      prod = 128'(p[r]) * 128'(entry_of(r, c));
      acc += prod >>> FB;
    end
    return acc;
  endfunction

  function automatic logic [31:0] quotient(logic signed [127:0] num,
                                           logic signed [127:0] w, inout bit sat);
    logic [127:0] n, d, ip, rem, q;
    bit neg;
    neg = (num < 0) != (w < 0);
    n = num < 0 ? -num : num;
    d = w < 0 ? -w : w;
    ip = n / d;
    rem = n % d;
    if (ip >= (128'd1 << (32 - FB))) begin
      q = 128'd1 << 33;
    end else begin
      q = ip;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem -= d;
          q |= 1;
        end
      end
    end
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic proj_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic signed [63:0] p [3];
    logic signed [127:0] w;
    logic [31:0] o [3];
    proj_t r;
    bit sat;
    sat = 1'b0;
    p[0] = 64'(signed'(x));
    p[1] = 64'(signed'(y));
    p[2] = 64'(signed'(z));
    w = column_sum(p, 3);
    if (w == 0) begin
      r = '{x: '0, y: '0, z: '0, st: STAT_WZERO};
      return r;
    end
    for (int c = 0; c < 3; c++) o[c] = quotient(column_sum(p, c), w, sat);
    r = '{x: o[0], y: o[1], z: o[2], st: sat ? STAT_SAT : STAT_OK};
    return r;
  endfunction

  task automatic write_reg(int idx, logic [63:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = IDX_W'(idx);
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx < NUM_REGS) matrix[idx] = v;
  endtask

  task automatic load_identity();
    write_reg(0, ONE << 32);
    write_reg(1, 0);
    write_reg(2, ONE);
    write_reg(3, 0);
    write_reg(4, 0);
    write_reg(5, ONE << 32);
    write_reg(6, 0);
    write_reg(7, ONE);
  endtask

  task automatic drain_pipe();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LAT + 4) @(negedge clk_i);
  endtask

  // close a burst that is still open
  task automatic end_burst(inout int burst);
    if (burst != 0) in_valid_i <= 1'b0;
    burst = 0;
  endtask

  // one beat in, with a random gap before each new burst
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit chk, proj_t res, inout int burst);
    proj_t e;
    if (burst == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst = $urandom_range(1, 20);
    end
    burst--;
    e = project_point(x, y, z);
    if (chk && e != res) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("table row disagrees with predictor: %h vs %h", res, e);
    end
    in_valid_i <= 1'b1;
    x_in_i <= x;
    y_in_i <= y;
    z_in_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(e);
    @(negedge clk_i);
    if (burst == 0) in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'(signed'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h0;
      default: return 32'(signed'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
    endcase
  endfunction

  // sink stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_busy) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) sink_busy <= ~sink_busy;
  end

  always @(posedge clk_i) begin
    proj_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat %h %h %h", x_out_o, y_out_o,
                                       z_out_o);
      end else begin
        e = expected_q.pop_front();
        if (e.x !== x_out_o || e.y !== y_out_o || e.z !== z_out_o || e.st !== status_o) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %h %h %h st %0d, got %h %h %h st %0d",
                     e.x, e.y, e.z, e.st, x_out_o, y_out_o, z_out_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= MAX_CYC) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  dir_row_t dir_tab [N_DIR];

  initial begin
    int burst;
    int dummy;
    proj_t none;
    none = '0;
    burst = 0;
    // identity: point passes through, table row checked against the predictor
    dir_tab[0]  = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b1,
                    '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, STAT_OK}};
    dir_tab[1]  = '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, STAT_OK}};
    dir_tab[2]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, STAT_OK}};
    dir_tab[3]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, STAT_OK}};
    dir_tab[4]  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_5555, 1'b0, none};
    dir_tab[5]  = '{32'h5555_AAAA, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, none};
    // with w taken from z: zero w, tiny w (saturates), negative w
    dir_tab[6]  = '{32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, STAT_WZERO}};
    dir_tab[7]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, none};
    dir_tab[8]  = '{32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0000, 1'b0, none};
    dir_tab[9]  = '{32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, none};
    dir_tab[10] = '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, none};
    dir_tab[11] = '{32'h0000_0001, 32'h0000_0003, 32'h0000_0007, 1'b0, none};
    dir_tab[12] = '{32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, none};
    dir_tab[13] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, none};

    for (int i = 0; i < NUM_REGS; i++) matrix[i] = '0;
    matrix[0] = ONE << 32;
    matrix[2] = ONE;
    matrix[5] = ONE << 32;
    matrix[7] = ONE;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 6; i++)
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].chk, dir_tab[i].res, burst);
    end_burst(burst);
    drain_pipe();
    // w column = z, plus two out-of-range indices that must be ignored
    write_reg(7, 64'h0);
    write_reg(5, (ONE << 32) | ONE);
    write_reg(8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(15, 64'h1234_5678_9ABC_DEF0);
    for (int i = 6; i < N_DIR; i++)
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].chk, dir_tab[i].res, burst);
    end_burst(burst);
    drain_pipe();

    // random phases: all-ones matrix, extreme matrix, random perspective matrices, identity
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (ph)
          0: write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
          1: write_reg(i, (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
          default: write_reg(i, {rand_entry(), rand_entry()});
        endcase
      end
      if (ph == 4) load_identity();
      for (int k = 0; k < N_RAND / 5; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none, burst);
      end_burst(burst);
      drain_pipe();
    end

    dummy = 0;
    while (expected_q.size() != 0 && dummy < 100000) begin
      @(negedge clk_i);
      dummy++;
    end
    repeat (LAT + 4) @(negedge clk_i);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
